FILE: rtl/work_stealing_deque_assert.svh
// Assertion macros shared by the deque RTL.
`ifndef WORK_STEALING_DEQUE_ASSERT_SVH
`define WORK_STEALING_DEQUE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define WSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define WSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/wsd_pkg.sv
package wsd_pkg;

   localparam int ItemWidth  = 64;
   localparam int CountWidth = 11;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_STEAL = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [ItemWidth-1:0] push_item;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [ItemWidth-1:0]  out_item;
      logic [CountWidth-1:0] count;
   } rsp_type;

endpackage

FILE: rtl/work_stealing_deque.sv
// Channel   Ports                         Direction  Handshake
// request   start, busy, req_data         in         taken when start is high and busy low
// response  rsp_valid, rsp_data           out        one-cycle strobe, cannot be held off
//
// Every word yields one response in the cycle after it is taken; a new word may be
// taken in every cycle, so the sustained rate is one word per cycle.
// The item store is a single-port synchronous memory: a push writes it and a pop or
// steal reads it at the accepting edge, and the read word appears with the strobe.
// Reset clears both indices at once; the store itself needs no clearing pass.
// The response side has no stall, so busy never rises.
`include "work_stealing_deque_assert.svh"

module work_stealing_deque
   import wsd_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int SPAN = 2 * DEPTH;
   localparam int IW   = $clog2(SPAN);
   localparam int AW   = $clog2(DEPTH);

   logic [ItemWidth-1:0] store_mem [DEPTH];

   logic [IW-1:0]         top_ff, top_in;
   logic [IW-1:0]         bottom_ff, bottom_in;
   logic                  rsp_valid_ff;
   logic [1:0]            status_ff, status_in;
   logic [CountWidth-1:0] count_ff;
   logic                  take_ff, take_in;
   logic [ItemWidth-1:0]  rd_data_ff;

   logic          accept;
   logic [IW-1:0] held_now, held_next;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
      return (x == IW'(SPAN - 1)) ? '0 : x + IW'(1);
   endfunction

   function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] x);
      return (x == '0) ? IW'(SPAN - 1) : x - IW'(1);
   endfunction

   function automatic logic [AW-1:0] slot(input logic [IW-1:0] x);
      logic [IW-1:0] d;
      d = x - IW'(DEPTH);
      return (x >= IW'(DEPTH)) ? d[AW-1:0] : x[AW-1:0];
   endfunction

   function automatic logic [IW-1:0] held(input logic [IW-1:0] b, input logic [IW-1:0] t);
      logic [IW:0] wrapped;
      wrapped = {1'b0, b} + (IW+1)'(SPAN) - {1'b0, t};
      return (b >= t) ? b - t : wrapped[IW-1:0];
   endfunction

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign held_now = held(bottom_ff, top_ff);

   always_comb begin
      top_in    = top_ff;
      bottom_in = bottom_ff;
      status_in = ST_OK;
      take_in   = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = slot(bottom_ff);
      rd_addr   = slot(top_ff);
      if (accept) begin
         case (req_data.opcode)
            OP_PUSH: begin
               if (held_now >= IW'(DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en     = 1'b1;
                  bottom_in = wrap_inc(bottom_ff);
               end
            end
            OP_POP: begin
               if (held_now == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  bottom_in = wrap_dec(bottom_ff);
                  rd_addr   = slot(wrap_dec(bottom_ff));
                  rd_en     = 1'b1;
                  take_in   = 1'b1;
               end
            end
            OP_STEAL: begin
               if (held_now == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  top_in  = wrap_inc(top_ff);
                  rd_en   = 1'b1;
                  take_in = 1'b1;
               end
            end
            default: begin
               top_in = bottom_ff;
            end
         endcase
      end
   end

   assign held_next = held(bottom_in, top_in);

   // Pop and steal read an entry that an earlier push has already written, so a read
   // never meets a write to the same entry in one cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req_data.push_item;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         bottom_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         take_ff      <= 1'b0;
      end else begin
         top_ff       <= top_in;
         bottom_ff    <= bottom_in;
         rsp_valid_ff <= accept;
         take_ff      <= take_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         count_ff  <= CountWidth'(held_next);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data.status   = status_ff;
   assign rsp_data.out_item = take_ff ? rd_data_ff : '0;
   assign rsp_data.count    = count_ff;

   `WSD_ASSERT(a_held_bound, clock, reset, held_now <= IW'(DEPTH), "deque holds more than DEPTH words")
   `WSD_ASSERT(a_one_rsp, clock, reset, accept |=> rsp_valid, "accepted word gave no response")
   `WSD_ASSERT(a_full_held, clock, reset,
      (rsp_valid && rsp_data.status == ST_FULL) |-> held_now == IW'(DEPTH),
      "full status while the store has room")
   `WSD_ASSERT(a_empty_take, clock, reset,
      (rsp_valid && rsp_data.status != ST_OK) |-> !take_ff,
      "item returned with a failing status")
   `WSD_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid,
      "response strobe straight after reset")

endmodule

FILE: tb/sv/work_stealing_deque_test.sv
`timescale 1ns / 100ps

module work_stealing_deque_test
   import wsd_pkg::*;
();

   localparam int Depth = 1024;
   localparam int QuietLimit = 2000;

   // Tracks the deque contents and queues the response word each request should produce.
   class deque_scoreboard;
      logic [ItemWidth-1:0] item_slots [Depth];
      int unsigned top_idx;
      int unsigned bottom_idx;
      rsp_type expected_rsps [$];
      int mismatch_count;

      function new();
         top_idx = 0;
         bottom_idx = 0;
         mismatch_count = 0;
      endfunction

      function int unsigned held();
         return (bottom_idx + 2 * Depth - top_idx) % (2 * Depth);
      endfunction

      function void note_word(req_type w);
         rsp_type want;
         int unsigned n;
         n = held();
         want.status = ST_OK;
         want.out_item = '0;
         case (w.opcode)
            OP_PUSH: begin
               if (n >= Depth) begin
                  want.status = ST_FULL;
               end else begin
                  item_slots[bottom_idx % Depth] = w.push_item;
                  bottom_idx = (bottom_idx + 1) % (2 * Depth);
               end
            end
            OP_POP: begin
               if (n == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  bottom_idx = (bottom_idx + 2 * Depth - 1) % (2 * Depth);
                  want.out_item = item_slots[bottom_idx % Depth];
               end
            end
            OP_STEAL: begin
               if (n == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  want.out_item = item_slots[top_idx % Depth];
                  top_idx = (top_idx + 1) % (2 * Depth);
               end
            end
            default: begin
               top_idx = bottom_idx;
            end
         endcase
         want.count = CountWidth'(held());
         expected_rsps.push_back(want);
      endfunction

      task report(string what);
         if (mismatch_count < 50) begin
            $display("mismatch at %0t: %s", $realtime, what);
         end
         mismatch_count++;
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            report($sformatf("response word with none outstanding, status %0d", got.status));
            return;
         end
         want = expected_rsps.pop_front();
         if (got.status !== want.status) begin
            report($sformatf("status %0d, wanted %0d", got.status, want.status));
         end
         if (got.out_item !== want.out_item) begin
            report($sformatf("item %h, wanted %h", got.out_item, want.out_item));
         end
         if (got.count !== want.count) begin
            report($sformatf("count %0d, wanted %0d", got.count, want.count));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   deque_scoreboard sb = new();
   int idle_pct = 0;
   int quiet_cycles = 0;

   work_stealing_deque #(
      .DEPTH(Depth)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && rsp_valid) begin
         sb.check_word(rsp_data);
      end
   end

   initial begin
      wait (quiet_cycles >= QuietLimit);
      $display("status: fail");
      $finish;
   end

   function automatic req_type make_word(logic [1:0] op, logic [ItemWidth-1:0] item);
      req_type w;
      w.opcode = op;
      w.push_item = item;
      return w;
   endfunction

   function automatic logic [ItemWidth-1:0] random_item();
      case ($urandom_range(9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return {$urandom, $urandom};
         end
      endcase
   endfunction

   // The word is noted at the edge that takes it; its response follows in the cycle after.
   task automatic send_word(input req_type w);
      req_type junk;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         junk.opcode = 2'($urandom_range(3));
         junk.push_item = {$urandom, $urandom};
         start <= 1'b0;
         req_data <= junk;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy !== 1'b0) begin
         @(posedge clock);
      end
      sb.note_word(w);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_rsps.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic run_mix(input int n);
      int r;
      logic [1:0] op;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 50) begin
            op = OP_PUSH;
         end else if (r < 70) begin
            op = OP_POP;
         end else if (r < 96) begin
            op = OP_STEAL;
         end else begin
            op = OP_CLEAR;
         end
         send_word(make_word(op, random_item()));
      end
   endtask

   // Fills the deque up to the given level, then empties it again, mostly by
   // stealing, until several removals have found it empty.
   task automatic fill_and_drain(input int level);
      int empty_hits;
      empty_hits = 0;
      while (sb.held() < level) begin
         if ($urandom_range(99) < 3) begin
            send_word(make_word(OP_STEAL, random_item()));
         end else begin
            send_word(make_word(OP_PUSH, random_item()));
         end
      end
      while (empty_hits < 3) begin
         if (sb.held() == 0) begin
            empty_hits++;
         end
         if ($urandom_range(99) < 70) begin
            send_word(make_word(OP_STEAL, random_item()));
         end else begin
            send_word(make_word(OP_POP, random_item()));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      send_word(make_word(OP_POP, '1));
      send_word(make_word(OP_STEAL, '1));
      send_word(make_word(OP_CLEAR, '1));
      send_word(make_word(OP_PUSH, '0));
      send_word(make_word(OP_PUSH, '1));
      send_word(make_word(OP_PUSH, 64'haaaa_aaaa_aaaa_aaaa));
      send_word(make_word(OP_PUSH, 64'h5555_5555_5555_5555));
      send_word(make_word(OP_POP, '0));
      send_word(make_word(OP_STEAL, '0));
      send_word(make_word(OP_STEAL, '0));
      send_word(make_word(OP_STEAL, '0));
      send_word(make_word(OP_STEAL, '0));
      send_word(make_word(OP_PUSH, 64'h8000_0000_0000_0001));
      send_word(make_word(OP_PUSH, 64'h0123_4567_89ab_cdef));
      send_word(make_word(OP_CLEAR, '0));
      send_word(make_word(OP_POP, '0));
      send_word(make_word(OP_PUSH, 64'd1));
      send_word(make_word(OP_POP, '1));
      send_word(make_word(OP_POP, '1));
      run_mix(110);

      idle_pct = 72;
      run_mix(110);
      pause_until_drained();

      idle_pct = 14;
      fill_and_drain(80);
      run_mix(110);

      idle_pct = 0;
      fill_and_drain(80);

      idle_pct = 72;
      run_mix(110);

      pause_until_drained();
      repeat (8) @(posedge clock);
      if (sb.expected_rsps.size() != 0) begin
         sb.report("responses still outstanding at the end");
      end
      if (sb.mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
